// ===== hdl/edc_pkg.sv =====
// Shared types and constants of the elevator dispatch controller.
package edc_pkg;

    // Fixed field widths of the transaction payload
    localparam int FLOOR_W      = 5;
    localparam int CABIN_IDX_W  = 2;
    localparam int ACTION_W     = 2;
    localparam int DIR_W        = 2;
    localparam int CFG_FLOORS_W = 5;
    localparam int CFG_CABINS_W = 3;
    localparam int CFG_DATA_W   = 5;
    localparam int CFG_IDX_W    = 1;
    localparam int OUT_CABINS   = 4;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FLOORS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_CABINS = 1'b1;

    // Request kinds
    typedef enum logic [ACTION_W-1:0] {
        ACT_HALL  = 2'd0,
        ACT_CABIN = 2'd1,
        ACT_TICK  = 2'd2
    } t_action;

    // Cabin heading codes, also used for the hall call direction
    typedef enum logic [DIR_W-1:0] {
        HEAD_IDLE = 2'd0,
        HEAD_UP   = 2'd1,
        HEAD_DOWN = 2'd2
    } t_heading;

    // Per-cabin update command for one step
    typedef struct packed {
        logic               tick;
        logic               toggle;
        logic [FLOOR_W-1:0] floor;
    } t_cabin_cmd;

endpackage

// ===== hdl/edc_req_if.sv =====
// Request channel: one hall call, cabin call or movement tick per transaction.
interface edc_req_if;
    logic                             valid;
    logic                             ready;
    logic [edc_pkg::ACTION_W-1:0]     action;
    logic [edc_pkg::FLOOR_W-1:0]      floor;
    logic [edc_pkg::DIR_W-1:0]        call_direction;
    logic [edc_pkg::CABIN_IDX_W-1:0]  cabin_index;

    modport source (output valid, action, floor, call_direction, cabin_index, input ready);
    modport sink   (input valid, action, floor, call_direction, cabin_index, output ready);
endinterface

// ===== hdl/edc_rsp_if.sv =====
// Result channel: dispatch outcome and all cabin positions after the step.
interface edc_rsp_if;
    logic                             valid;
    logic                             ready;
    logic [edc_pkg::CABIN_IDX_W-1:0]  served_cabin;
    logic                             request_rejected;
    logic [edc_pkg::FLOOR_W-1:0]      cabin0_floor;
    logic [edc_pkg::FLOOR_W-1:0]      cabin1_floor;
    logic [edc_pkg::FLOOR_W-1:0]      cabin2_floor;
    logic [edc_pkg::FLOOR_W-1:0]      cabin3_floor;
    logic [edc_pkg::DIR_W-1:0]        cabin0_heading;
    logic [edc_pkg::DIR_W-1:0]        cabin1_heading;
    logic [edc_pkg::DIR_W-1:0]        cabin2_heading;
    logic [edc_pkg::DIR_W-1:0]        cabin3_heading;

    modport source (output valid, served_cabin, request_rejected,
                    cabin0_floor, cabin1_floor, cabin2_floor, cabin3_floor,
                    cabin0_heading, cabin1_heading, cabin2_heading, cabin3_heading,
                    input ready);
    modport sink   (input valid, served_cabin, request_rejected,
                    cabin0_floor, cabin1_floor, cabin2_floor, cabin3_floor,
                    cabin0_heading, cabin1_heading, cabin2_heading, cabin3_heading,
                    output ready);
endinterface

// ===== hdl/edc_cabin.sv =====
// One cabin: floor, heading and lit buttons, with move, toggle and heading logic.
module edc_cabin #(
    parameter int MAX_FLOORS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  edc_pkg::t_cabin_cmd             i_cmd,
    input  logic [edc_pkg::FLOOR_W-1:0]     i_floors_eff,
    output logic [edc_pkg::FLOOR_W-1:0]     o_floor,
    output edc_pkg::t_heading               o_heading,
    output logic [edc_pkg::FLOOR_W-1:0]     o_next_floor,
    output edc_pkg::t_heading               o_next_heading
);

    localparam int IW = (MAX_FLOORS > 1) ? $clog2(MAX_FLOORS) : 1;
    localparam int CW = ((IW + 1 > edc_pkg::FLOOR_W) ? IW + 1 : edc_pkg::FLOOR_W) + 1;

    logic [edc_pkg::FLOOR_W-1:0] r_floor, n_floor;
    edc_pkg::t_heading           r_heading, n_heading, calc_heading;
    logic [MAX_FLOORS-1:0]       r_lit, n_lit, masked;
    logic                        recompute, found;
    logic [IW-1:0]               low_idx;
    logic [CW-1:0]               low_floor, cur_floor;

    // Toggle the requested button and move one floor on a tick
    always_comb begin
        n_lit     = r_lit;
        n_floor   = r_floor;
        recompute = i_cmd.toggle;
        if (i_cmd.toggle) begin
            n_lit = r_lit ^ ({{(MAX_FLOORS-1){1'b0}}, 1'b1}
                             << (i_cmd.floor - edc_pkg::FLOOR_W'(1)));
        end
        if (i_cmd.tick) begin
            case (r_heading)
                edc_pkg::HEAD_UP: begin
                    recompute = 1'b1;
                    if (CW'(r_floor) < CW'(MAX_FLOORS)) begin
                        n_floor = r_floor + edc_pkg::FLOOR_W'(1);
                    end
                end
                edc_pkg::HEAD_DOWN: begin
                    recompute = 1'b1;
                    if (r_floor > edc_pkg::FLOOR_W'(1)) begin
                        n_floor = r_floor - edc_pkg::FLOOR_W'(1);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Find the lowest lit floor among the floors in use
    always_comb begin
        found   = 1'b0;
        low_idx = '0;
        for (int i = 0; i < MAX_FLOORS; i++) begin
            masked[i] = n_lit[i] & (CW'(i) < CW'(i_floors_eff));
        end
        for (int i = MAX_FLOORS - 1; i >= 0; i--) begin
            if (masked[i]) begin
                found   = 1'b1;
                low_idx = IW'(i);
            end
        end
    end

    // Head toward the lowest lit floor, idle when there or when none is lit
    always_comb begin
        low_floor = CW'(low_idx) + CW'(1);
        cur_floor = CW'(n_floor);
        if (!found) begin
            calc_heading = edc_pkg::HEAD_IDLE;
        end else if (low_floor > cur_floor) begin
            calc_heading = edc_pkg::HEAD_UP;
        end else if (low_floor < cur_floor) begin
            calc_heading = edc_pkg::HEAD_DOWN;
        end else begin
            calc_heading = edc_pkg::HEAD_IDLE;
        end
        n_heading = recompute ? calc_heading : r_heading;
    end

    // Hold cabin state; an empty command leaves it unchanged
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_floor   <= edc_pkg::FLOOR_W'(1);
            r_heading <= edc_pkg::HEAD_IDLE;
            r_lit     <= '0;
        end else begin
            r_floor   <= n_floor;
            r_heading <= n_heading;
            r_lit     <= n_lit;
        end
    end

    assign o_floor        = r_floor;
    assign o_heading      = r_heading;
    assign o_next_floor   = n_floor;
    assign o_next_heading = n_heading;

endmodule

// ===== hdl/edc_select.sv =====
// Hall call dispatch: pick the nearest cabin, preferring a matching heading on ties.
module edc_select #(
    parameter int CABINS = 4
) (
    input  logic [edc_pkg::FLOOR_W-1:0]                    i_floors [CABINS],
    input  edc_pkg::t_heading                              i_headings [CABINS],
    input  logic [$clog2(CABINS+1)-1:0]                    i_cabins_eff,
    input  logic [edc_pkg::FLOOR_W-1:0]                    i_floor,
    input  logic [edc_pkg::DIR_W-1:0]                      i_dir,
    output logic [((CABINS > 1) ? $clog2(CABINS) : 1)-1:0] o_best
);

    localparam int CIW = (CABINS > 1) ? $clog2(CABINS) : 1;
    localparam int NCW = $clog2(CABINS + 1);
    localparam int KW  = ((NCW > CIW) ? NCW : CIW) + 1;

    logic [edc_pkg::FLOOR_W-1:0] cab_gap [CABINS];
    logic [CABINS-1:0]           part, match, tied;
    logic [edc_pkg::FLOOR_W-1:0] d_min;
    logic                        match_ok, any_match;
    logic [CIW-1:0]              first_tied, last_match;

    // Distance of each cabin to the call and its heading match
    always_comb begin
        match_ok = (i_dir == edc_pkg::HEAD_UP) || (i_dir == edc_pkg::HEAD_DOWN);
        for (int c = 0; c < CABINS; c++) begin
            cab_gap[c] = (i_floors[c] > i_floor) ? i_floors[c] - i_floor
                                                 : i_floor - i_floors[c];
            part[c]    = (KW'(c) < KW'(i_cabins_eff)) || (c == 0);
            match[c]   = match_ok && (i_headings[c] == i_dir);
        end
    end

    // Least distance over cabins in use
    always_comb begin
        d_min = cab_gap[0];
        for (int c = 1; c < CABINS; c++) begin
            if (part[c] && (cab_gap[c] < d_min)) begin
                d_min = cab_gap[c];
            end
        end
    end

    // Last tied cabin with matching heading, else first tied cabin
    always_comb begin
        first_tied = '0;
        last_match = '0;
        any_match  = 1'b0;
        for (int c = 0; c < CABINS; c++) begin
            tied[c] = part[c] && (cab_gap[c] == d_min);
        end
        for (int c = CABINS - 1; c >= 0; c--) begin
            if (tied[c]) begin
                first_tied = CIW'(c);
            end
        end
        for (int c = 0; c < CABINS; c++) begin
            if (tied[c] && match[c]) begin
                last_match = CIW'(c);
                any_match  = 1'b1;
            end
        end
        o_best = any_match ? last_match : first_tied;
    end

endmodule

// ===== hdl/elevator_dispatch_controller.sv =====
// Top level of the nearest-car elevator dispatch controller.
// Takes one request transaction per clock (hall call, cabin call or movement tick) while results
// are taken, and returns one result per request, carrying the served cabin, a reject flag for an
// out-of-range floor or cabin, and the floor and heading of cabins zero to three after the step.
// An accepted request is held in the input register, and its result moves to the output register
// once that register is free or drained; one request per cycle is sustained while the output is
// not stalled, set by the single pass through the nearest-cabin select and the per-cabin
// lowest-lit-floor search. Configuration writes take effect on the following edge; the user must
// make them only while no request is in flight, and the block itself does not enforce this.
module elevator_dispatch_controller #(
    parameter int MAX_FLOORS = 16,
    parameter int CABINS     = 4
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    edc_req_if.sink                           i_req,
    edc_rsp_if.source                         o_rsp,
    input  logic                              i_cfg_we,
    input  logic [edc_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [edc_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int FW  = edc_pkg::FLOOR_W;
    localparam int CIW = (CABINS > 1) ? $clog2(CABINS) : 1;
    localparam int NCW = $clog2(CABINS + 1);
    localparam int TW  = (($clog2(MAX_FLOORS + 1) > FW) ? $clog2(MAX_FLOORS + 1) : FW) + 1;
    localparam int EW  = ((NCW > edc_pkg::CFG_CABINS_W) ? NCW : edc_pkg::CFG_CABINS_W) + 1;
    localparam int SW  = ((CIW > edc_pkg::CABIN_IDX_W) ? CIW : edc_pkg::CABIN_IDX_W) + 1;

    // Configuration registers
    logic [edc_pkg::CFG_FLOORS_W-1:0] r_cfg_floors;
    logic [edc_pkg::CFG_CABINS_W-1:0] r_cfg_cabins;

    // Input stage
    logic                             r_in_vld;
    logic [edc_pkg::ACTION_W-1:0]     r_action;
    logic [FW-1:0]                    r_floor;
    logic [edc_pkg::DIR_W-1:0]        r_dir;
    logic [edc_pkg::CABIN_IDX_W-1:0]  r_idx;

    // Output stage
    logic                             r_out_vld;
    logic [edc_pkg::CABIN_IDX_W-1:0]  r_served;
    logic                             r_rejected;
    logic [FW-1:0]                    r_out_floor [edc_pkg::OUT_CABINS];
    edc_pkg::t_heading                r_out_head  [edc_pkg::OUT_CABINS];

    logic                             fire;
    logic [FW-1:0]                    floors_eff;
    logic [NCW-1:0]                   cabins_eff;
    logic                             floor_ok, idx_ok;
    logic                             do_tick, do_toggle;
    logic [SW-1:0]                    toggle_tgt;
    logic [CIW-1:0]                   best;
    logic [edc_pkg::CABIN_IDX_W-1:0]  n_served;
    logic                             n_rejected;

    logic [FW-1:0]                    cab_floor      [CABINS];
    edc_pkg::t_heading                cab_head       [CABINS];
    logic [FW-1:0]                    cab_next_floor [CABINS];
    edc_pkg::t_heading                cab_next_head  [CABINS];

    // Store configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_floors <= edc_pkg::CFG_FLOORS_W'(16);
            r_cfg_cabins <= edc_pkg::CFG_CABINS_W'(4);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                edc_pkg::CFG_FLOORS: r_cfg_floors <= i_cfg_data[edc_pkg::CFG_FLOORS_W-1:0];
                edc_pkg::CFG_CABINS: r_cfg_cabins <= i_cfg_data[edc_pkg::CFG_CABINS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Saturate the configuration to the supported ranges
    always_comb begin
        if (r_cfg_floors < edc_pkg::CFG_FLOORS_W'(2)) begin
            floors_eff = FW'(2);
        end else if (TW'(r_cfg_floors) > TW'(MAX_FLOORS)) begin
            floors_eff = FW'(MAX_FLOORS);
        end else begin
            floors_eff = FW'(r_cfg_floors);
        end
        if (r_cfg_cabins == '0) begin
            cabins_eff = NCW'(1);
        end else if (EW'(r_cfg_cabins) > EW'(CABINS)) begin
            cabins_eff = NCW'(CABINS);
        end else begin
            cabins_eff = NCW'(r_cfg_cabins);
        end
    end

    // Advance the pipeline when the output register is free or drained
    assign fire        = r_in_vld && (!r_out_vld || o_rsp.ready);
    assign i_req.ready = !r_in_vld || fire;

    // Capture an accepted transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_req.ready) begin
            r_in_vld <= i_req.valid;
        end
        if (i_req.valid && i_req.ready) begin
            r_action <= i_req.action;
            r_floor  <= i_req.floor;
            r_dir    <= i_req.call_direction;
            r_idx    <= i_req.cabin_index;
        end
    end

    edc_select #(
        .CABINS (CABINS)
    ) u_select (
        .i_floors     (cab_floor),
        .i_headings   (cab_head),
        .i_cabins_eff (cabins_eff),
        .i_floor      (r_floor),
        .i_dir        (r_dir),
        .o_best       (best)
    );

    // Decode the request and check its range
    always_comb begin
        floor_ok   = (r_floor != '0) && (r_floor <= floors_eff);
        idx_ok     = (EW'(r_idx) < EW'(cabins_eff));
        do_tick    = 1'b0;
        do_toggle  = 1'b0;
        toggle_tgt = '0;
        n_served   = '0;
        n_rejected = 1'b0;
        case (edc_pkg::t_action'(r_action))
            edc_pkg::ACT_HALL: begin
                if (!floor_ok) begin
                    n_rejected = 1'b1;
                end else begin
                    do_toggle  = 1'b1;
                    toggle_tgt = SW'(best);
                    n_served   = edc_pkg::CABIN_IDX_W'(best);
                end
            end
            edc_pkg::ACT_CABIN: begin
                if (!floor_ok || !idx_ok) begin
                    n_rejected = 1'b1;
                end else begin
                    do_toggle  = 1'b1;
                    toggle_tgt = SW'(r_idx);
                    n_served   = r_idx;
                end
            end
            edc_pkg::ACT_TICK: begin
                do_tick = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // Cabin state, updated only on the cycle a transaction moves to the output
    for (genvar c = 0; c < CABINS; c++) begin : g_cabin
        edc_pkg::t_cabin_cmd cmd;

        assign cmd.tick   = fire && do_tick && (EW'(c) < EW'(cabins_eff));
        assign cmd.toggle = fire && do_toggle && (toggle_tgt == SW'(c));
        assign cmd.floor  = r_floor;

        edc_cabin #(
            .MAX_FLOORS (MAX_FLOORS)
        ) u_cabin (
            .i_clk          (i_clk),
            .i_rst_n        (i_rst_n),
            .i_cmd          (cmd),
            .i_floors_eff   (floors_eff),
            .o_floor        (cab_floor[c]),
            .o_heading      (cab_head[c]),
            .o_next_floor   (cab_next_floor[c]),
            .o_next_heading (cab_next_head[c])
        );
    end

    // Hold the result until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (fire) begin
            r_out_vld <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_vld <= 1'b0;
        end
        if (fire) begin
            r_served   <= n_served;
            r_rejected <= n_rejected;
        end
    end

    for (genvar k = 0; k < edc_pkg::OUT_CABINS; k++) begin : g_out
        if (k < CABINS) begin : g_live
            always_ff @(posedge i_clk) begin
                if (fire) begin
                    r_out_floor[k] <= cab_next_floor[k];
                    r_out_head[k]  <= cab_next_head[k];
                end
            end
        end else begin : g_absent
            always_ff @(posedge i_clk) begin
                r_out_floor[k] <= '0;
                r_out_head[k]  <= edc_pkg::HEAD_IDLE;
            end
        end
    end

    assign o_rsp.valid            = r_out_vld;
    assign o_rsp.served_cabin     = r_served;
    assign o_rsp.request_rejected = r_rejected;
    assign o_rsp.cabin0_floor     = r_out_floor[0];
    assign o_rsp.cabin1_floor     = r_out_floor[1];
    assign o_rsp.cabin2_floor     = r_out_floor[2];
    assign o_rsp.cabin3_floor     = r_out_floor[3];
    assign o_rsp.cabin0_heading   = r_out_head[0];
    assign o_rsp.cabin1_heading   = r_out_head[1];
    assign o_rsp.cabin2_heading   = r_out_head[2];
    assign o_rsp.cabin3_heading   = r_out_head[3];

endmodule

// ===== test/tb_elevator_dispatch_controller.sv =====
// Testbench of the elevator dispatch controller: directed call table plus predicted random calls.
module tb_elevator_dispatch_controller;

    localparam int MAX_FLOORS  = 16;
    localparam int CABINS      = 4;
    localparam int CYCLE_LIMIT = 400000;
    localparam int LONG_HOLD   = 60;
    localparam int PHASE_CALLS = 240;
    localparam int PHASES      = 8;

    // Request code that the block decodes to nothing, and a direction that is neither up nor down
    localparam logic [edc_pkg::ACTION_W-1:0] ACT_SPARE = 2'd3;
    localparam logic [edc_pkg::DIR_W-1:0]    DIR_BAD   = 2'd3;

    typedef struct packed {
        logic [edc_pkg::ACTION_W-1:0]    action;
        logic [edc_pkg::FLOOR_W-1:0]     floor;
        logic [edc_pkg::DIR_W-1:0]       dir;
        logic [edc_pkg::CABIN_IDX_W-1:0] idx;
    } t_call;

    typedef struct packed {
        t_call                           call;
        logic                            typed;
        logic [edc_pkg::CABIN_IDX_W-1:0] served;
        logic                            rejected;
    } t_table_row;

    typedef struct packed {
        logic [edc_pkg::CABIN_IDX_W-1:0]                      served;
        logic                                                 rejected;
        logic [edc_pkg::OUT_CABINS-1:0][edc_pkg::FLOOR_W-1:0] flr;
        logic [edc_pkg::OUT_CABINS-1:0][edc_pkg::DIR_W-1:0]   head;
    } t_snapshot;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n;
    logic                            cfg_we;
    logic [edc_pkg::CFG_IDX_W-1:0]   cfg_idx;
    logic [edc_pkg::CFG_DATA_W-1:0]  cfg_data;

    edc_req_if req_ch();
    edc_rsp_if rsp_ch();

    // Predicted dispatch state and register copies
    logic [edc_pkg::FLOOR_W-1:0]      car_floor [CABINS];
    edc_pkg::t_heading                car_heading [CABINS];
    logic [MAX_FLOORS-1:0]            car_lit [CABINS];
    logic [edc_pkg::CFG_FLOORS_W-1:0] floors_reg;
    logic [edc_pkg::CFG_CABINS_W-1:0] cabins_reg;

    t_snapshot  expected_snapshots [$];
    t_table_row call_table [$];
    int         mismatches = 0;
    int         cycles = 0;
    bit         gaps_on;
    bit         stalls_on;
    bit         hold_pending;

    elevator_dispatch_controller #(
        .MAX_FLOORS (MAX_FLOORS),
        .CABINS     (CABINS)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req_ch),
        .o_rsp      (rsp_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // Abort a run that hangs
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Clamp the floor register to the served range
    function automatic int served_floors();
        int nf;
        nf = int'(floors_reg);
        if (nf < 2) nf = 2;
        if (nf > MAX_FLOORS) nf = MAX_FLOORS;
        return nf;
    endfunction

    // Clamp the cabin register to the installed cabins
    function automatic int active_cabins();
        int nc;
        nc = int'(cabins_reg);
        if (nc < 1) nc = 1;
        if (nc > CABINS) nc = CABINS;
        return nc;
    endfunction

    function automatic int floor_gap(input logic [edc_pkg::FLOOR_W-1:0] a,
                                     input logic [edc_pkg::FLOOR_W-1:0] b);
        return (a > b) ? int'(a - b) : int'(b - a);
    endfunction

    // Head toward the lowest lit floor within the served range
    function automatic void refresh_heading(input int c);
        int                nf;
        bit                found;
        edc_pkg::t_heading h;
        nf = served_floors();
        found = 1'b0;
        h = edc_pkg::HEAD_IDLE;
        for (int i = 0; i < nf; i++) begin
            if (!found && car_lit[c][i]) begin
                found = 1'b1;
                if (i + 1 > car_floor[c]) h = edc_pkg::HEAD_UP;
                else if (i + 1 < car_floor[c]) h = edc_pkg::HEAD_DOWN;
            end
        end
        car_heading[c] = h;
    endfunction

    function automatic void toggle_button(input int c, input logic [edc_pkg::FLOOR_W-1:0] fl);
        car_lit[c] = car_lit[c] ^ (MAX_FLOORS'(1) << (fl - 5'd1));
        refresh_heading(c);
    endfunction

    // Apply one call to the predicted state and return the result it must produce
    function automatic t_snapshot dispatch_step(input t_call cl);
        t_snapshot s;
        int        nf;
        int        nc;
        int        best;
        int        bestd;
        int        d;
        bit        dir_ok;
        nf = served_floors();
        nc = active_cabins();
        s = '0;
        if (cl.action == edc_pkg::ACT_HALL) begin
            if (cl.floor < 1 || cl.floor > nf) begin
                s.rejected = 1'b1;
            end else begin
                best = 0;
                bestd = floor_gap(car_floor[0], cl.floor);
                dir_ok = (cl.dir == edc_pkg::HEAD_UP) || (cl.dir == edc_pkg::HEAD_DOWN);
                // Strictly closer wins; a tie goes to a cabin already heading the call's way
                for (int c = 0; c < nc; c++) begin
                    d = floor_gap(car_floor[c], cl.floor);
                    if (d < bestd || (d == bestd && dir_ok && car_heading[c] == cl.dir)) begin
                        bestd = d;
                        best = c;
                    end
                end
                toggle_button(best, cl.floor);
                s.served = best[edc_pkg::CABIN_IDX_W-1:0];
            end
        end else if (cl.action == edc_pkg::ACT_CABIN) begin
            if (cl.floor < 1 || cl.floor > nf || cl.idx >= nc) begin
                s.rejected = 1'b1;
            end else begin
                toggle_button(cl.idx, cl.floor);
                s.served = cl.idx;
            end
        end else if (cl.action == edc_pkg::ACT_TICK) begin
            // Advance every moving cabin one floor, held inside the shaft
            for (int c = 0; c < nc; c++) begin
                if (car_heading[c] == edc_pkg::HEAD_UP) begin
                    if (car_floor[c] < MAX_FLOORS) car_floor[c] = car_floor[c] + 5'd1;
                    refresh_heading(c);
                end else if (car_heading[c] == edc_pkg::HEAD_DOWN) begin
                    if (car_floor[c] > 1) car_floor[c] = car_floor[c] - 5'd1;
                    refresh_heading(c);
                end
            end
        end
        for (int k = 0; k < edc_pkg::OUT_CABINS; k++) begin
            s.flr[k] = car_floor[k];
            s.head[k] = car_heading[k];
        end
        return s;
    endfunction

    // Mostly well-formed calls within the current setting, some raw noise
    function automatic t_call random_call();
        t_call cl;
        int    pick;
        pick = $urandom_range(0, 99);
        cl.action = edc_pkg::ACT_TICK;
        cl.floor = edc_pkg::FLOOR_W'($urandom_range(1, served_floors()));
        cl.dir = edc_pkg::DIR_W'($urandom_range(edc_pkg::HEAD_UP, edc_pkg::HEAD_DOWN));
        cl.idx = edc_pkg::CABIN_IDX_W'($urandom_range(0, CABINS - 1));
        if (pick < 38) begin
            cl.action = edc_pkg::ACT_HALL;
        end else if (pick < 62) begin
            cl.action = edc_pkg::ACT_CABIN;
            cl.idx = edc_pkg::CABIN_IDX_W'($urandom_range(0, active_cabins() - 1));
        end else if (pick >= 88) begin
            cl.action = edc_pkg::ACTION_W'($urandom_range(0, 3));
            cl.floor = edc_pkg::FLOOR_W'($urandom_range(0, 31));
            cl.dir = edc_pkg::DIR_W'($urandom_range(0, 3));
            cl.idx = edc_pkg::CABIN_IDX_W'($urandom_range(0, 3));
        end
        return cl;
    endfunction

    function automatic void add_row(input logic [edc_pkg::ACTION_W-1:0] act,
                                    input logic [edc_pkg::FLOOR_W-1:0] fl,
                                    input logic [edc_pkg::DIR_W-1:0] dir,
                                    input logic [edc_pkg::CABIN_IDX_W-1:0] idx,
                                    input logic typed,
                                    input logic [edc_pkg::CABIN_IDX_W-1:0] srv,
                                    input logic rej);
        t_table_row r;
        r.call.action = act;
        r.call.floor = fl;
        r.call.dir = dir;
        r.call.idx = idx;
        r.typed = typed;
        r.served = srv;
        r.rejected = rej;
        call_table = {call_table, r};
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("[%0d] mismatch on %s: got %0d, expected %0d", cycles, what, got, want);
        mismatches++;
    endtask

    // Offer one call, optionally after an idle burst, and log its expected result on acceptance
    task automatic send_call(input t_call cl, input logic typed,
                             input logic [edc_pkg::CABIN_IDX_W-1:0] want_served,
                             input logic want_rej);
        t_snapshot s;
        int        gap;
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 6);
            repeat (gap) begin
                @(negedge i_clk);
                req_ch.valid <= 1'b0;
            end
        end
        @(negedge i_clk);
        req_ch.valid <= 1'b1;
        req_ch.action <= cl.action;
        req_ch.floor <= cl.floor;
        req_ch.call_direction <= cl.dir;
        req_ch.cabin_index <= cl.idx;
        do @(posedge i_clk); while (req_ch.ready !== 1'b1);
        s = dispatch_step(cl);
        if (typed) begin
            s.served = want_served;
            s.rejected = want_rej;
        end
        expected_snapshots = {expected_snapshots, s};
    endtask

    // Drop valid and hold until every outstanding result is back
    task automatic wait_results();
        @(negedge i_clk);
        req_ch.valid <= 1'b0;
        while (expected_snapshots.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [edc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [edc_pkg::CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= data;
        @(negedge i_clk);
        cfg_we <= 1'b0;
        if (idx == edc_pkg::CFG_FLOORS) floors_reg = data;
        else cabins_reg = data[edc_pkg::CFG_CABINS_W-1:0];
    endtask

    // Result side: random stall bursts, plus one long hold-off on request
    initial begin
        int n;
        rsp_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_pending) begin
                hold_pending = 1'b0;
                rsp_ch.ready <= 1'b0;
                repeat (LONG_HOLD - 1) @(negedge i_clk);
            end else if (stalls_on && $urandom_range(0, 4) == 0) begin
                n = $urandom_range(1, 6);
                rsp_ch.ready <= 1'b0;
                repeat (n - 1) @(negedge i_clk);
            end else begin
                rsp_ch.ready <= i_rst_n;
            end
        end
    end

    // Compare each result transaction with the oldest expectation
    always @(posedge i_clk) begin : rsp_check
        t_snapshot want;
        t_snapshot got;
        if (i_rst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            got.served = rsp_ch.served_cabin;
            got.rejected = rsp_ch.request_rejected;
            got.flr = {rsp_ch.cabin3_floor, rsp_ch.cabin2_floor,
                       rsp_ch.cabin1_floor, rsp_ch.cabin0_floor};
            got.head = {rsp_ch.cabin3_heading, rsp_ch.cabin2_heading,
                        rsp_ch.cabin1_heading, rsp_ch.cabin0_heading};
            if (expected_snapshots.size() == 0) begin
                report_mismatch("result with nothing pending", got.served, 0);
            end else begin
                want = expected_snapshots.pop_front();
                if (got.served !== want.served)
                    report_mismatch("served_cabin", got.served, want.served);
                if (got.rejected !== want.rejected)
                    report_mismatch("request_rejected", got.rejected, want.rejected);
                for (int k = 0; k < edc_pkg::OUT_CABINS; k++) begin
                    if (got.flr[k] !== want.flr[k])
                        report_mismatch($sformatf("cabin%0d floor", k),
                                        got.flr[k], want.flr[k]);
                    if (got.head[k] !== want.head[k])
                        report_mismatch($sformatf("cabin%0d heading", k),
                                        got.head[k], want.head[k]);
                end
            end
        end
    end

    // Main sequence: reset, directed table, then random phases over several settings
    initial begin
        logic [edc_pkg::CFG_DATA_W-1:0] pf;
        logic [edc_pkg::CFG_DATA_W-1:0] pc;
        t_call                          cl;
        i_rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_idx = edc_pkg::CFG_FLOORS;
        cfg_data = '0;
        req_ch.valid = 1'b0;
        req_ch.action = edc_pkg::ACT_HALL;
        req_ch.floor = '0;
        req_ch.call_direction = edc_pkg::HEAD_IDLE;
        req_ch.cabin_index = '0;
        gaps_on = 1'b1;
        stalls_on = 1'b1;
        hold_pending = 1'b0;
        floors_reg = 5'd16;
        cabins_reg = 3'd4;
        for (int c = 0; c < CABINS; c++) begin
            car_floor[c] = 5'd1;
            car_heading[c] = edc_pkg::HEAD_IDLE;
            car_lit[c] = '0;
        end

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Rejections, the spare code and calls at the floor extremes
        add_row(edc_pkg::ACT_HALL,  5'd0,  edc_pkg::HEAD_UP,   2'd0, 1'b1, 2'd0, 1'b1);
        add_row(edc_pkg::ACT_HALL,  5'd17, edc_pkg::HEAD_DOWN, 2'd3, 1'b1, 2'd0, 1'b1);
        add_row(edc_pkg::ACT_HALL,  5'd31, DIR_BAD,            2'd1, 1'b1, 2'd0, 1'b1);
        add_row(edc_pkg::ACT_CABIN, 5'd0,  edc_pkg::HEAD_UP,   2'd0, 1'b1, 2'd0, 1'b1);
        add_row(edc_pkg::ACT_CABIN, 5'd31, edc_pkg::HEAD_DOWN, 2'd3, 1'b1, 2'd0, 1'b1);
        add_row(ACT_SPARE,          5'd5,  edc_pkg::HEAD_UP,   2'd2, 1'b1, 2'd0, 1'b0);
        add_row(edc_pkg::ACT_TICK,  5'd1,  edc_pkg::HEAD_IDLE, 2'd0, 1'b1, 2'd0, 1'b0);
        add_row(edc_pkg::ACT_HALL,  5'd1,  edc_pkg::HEAD_UP,   2'd0, 1'b1, 2'd0, 1'b0);
        add_row(edc_pkg::ACT_CABIN, 5'd16, edc_pkg::HEAD_UP,   2'd3, 1'b1, 2'd3, 1'b0);
        add_row(edc_pkg::ACT_CABIN, 5'd8,  edc_pkg::HEAD_UP,   2'd1, 1'b1, 2'd1, 1'b0);
        add_row(edc_pkg::ACT_CABIN, 5'd8,  edc_pkg::HEAD_UP,   2'd2, 1'b1, 2'd2, 1'b0);
        // Movement, ties decided by heading, and direction codes that match nothing
        add_row(edc_pkg::ACT_TICK,  5'd0,  edc_pkg::HEAD_IDLE, 2'd0, 1'b0, 2'd0, 1'b0);
        add_row(edc_pkg::ACT_HALL,  5'd2,  edc_pkg::HEAD_UP,   2'd0, 1'b0, 2'd0, 1'b0);
        add_row(edc_pkg::ACT_HALL,  5'd2,  edc_pkg::HEAD_IDLE, 2'd0, 1'b0, 2'd0, 1'b0);
        add_row(edc_pkg::ACT_HALL,  5'd2,  DIR_BAD,            2'd0, 1'b0, 2'd0, 1'b0);
        add_row(edc_pkg::ACT_TICK,  5'd0,  edc_pkg::HEAD_IDLE, 2'd0, 1'b0, 2'd0, 1'b0);
        add_row(edc_pkg::ACT_HALL,  5'd16, edc_pkg::HEAD_DOWN, 2'd0, 1'b0, 2'd0, 1'b0);
        add_row(edc_pkg::ACT_CABIN, 5'd1,  edc_pkg::HEAD_DOWN, 2'd0, 1'b0, 2'd0, 1'b0);
        add_row(edc_pkg::ACT_TICK,  5'd0,  edc_pkg::HEAD_IDLE, 2'd0, 1'b0, 2'd0, 1'b0);
        add_row(edc_pkg::ACT_HALL,  5'd9,  edc_pkg::HEAD_DOWN, 2'd2, 1'b0, 2'd0, 1'b0);
        add_row(edc_pkg::ACT_CABIN, 5'd16, edc_pkg::HEAD_UP,   2'd3, 1'b0, 2'd0, 1'b0);
        add_row(edc_pkg::ACT_TICK,  5'd0,  edc_pkg::HEAD_IDLE, 2'd0, 1'b0, 2'd0, 1'b0);
        add_row(edc_pkg::ACT_TICK,  5'd0,  edc_pkg::HEAD_IDLE, 2'd0, 1'b0, 2'd0, 1'b0);
        add_row(edc_pkg::ACT_HALL,  5'd16, edc_pkg::HEAD_UP,   2'd1, 1'b0, 2'd0, 1'b0);

        foreach (call_table[i])
            send_call(call_table[i].call, call_table[i].typed,
                      call_table[i].served, call_table[i].rejected);
        wait_results();

        for (int p = 0; p < PHASES; p++) begin
            // Pick the setting, saturating values and masked upper bits among them
            case (p)
                0: begin pf = 5'd2;  pc = 5'd1;  end
                1: begin pf = 5'd0;  pc = 5'd0;  end
                2: begin pf = 5'd31; pc = 5'd7;  end
                3: begin pf = 5'd1;  pc = 5'd2;  end
                4: begin pf = 5'd16; pc = 5'd27; end
                5: begin
                    pf = edc_pkg::CFG_DATA_W'($urandom_range(0, 31));
                    pc = edc_pkg::CFG_DATA_W'($urandom_range(0, 31));
                end
                6: begin pf = 5'd12; pc = 5'd31; end
                default: begin pf = 5'd16; pc = 5'd4; end
            endcase
            write_reg(edc_pkg::CFG_FLOORS, pf);
            write_reg(edc_pkg::CFG_CABINS, pc);
            if (p == PHASES - 1) begin
                gaps_on = 1'b0;
                stalls_on = 1'b0;
            end
            for (int n = 0; n < PHASE_CALLS; n++) begin
                if (p == 3 && n == 60) hold_pending = 1'b1;
                if (p == 4 && n == 100) wait_results();
                cl = random_call();
                send_call(cl, 1'b0, '0, 1'b0);
            end
            wait_results();
        end

        repeat (4) @(posedge i_clk);
        if (mismatches == 0) $display("SCOREBOARD CLEAN");
        else $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/edc_pkg.sv
hdl/edc_req_if.sv
hdl/edc_rsp_if.sv
hdl/edc_cabin.sv
hdl/edc_select.sv
hdl/elevator_dispatch_controller.sv
test/tb_elevator_dispatch_controller.sv
